// ----- design/wsdf_pkg.sv -----
// Shared types and constants for the WebSocket frame deframer.
package wsdf_pkg;

  typedef enum logic [2:0] {
    PH_HDR0  = 3'd0,
    PH_HDR1  = 3'd1,
    PH_EXT16 = 3'd2,
    PH_EXT64 = 3'd3,
    PH_KEY   = 3'd4,
    PH_DATA  = 3'd5
  } phase_e;

  localparam logic [7:0] OpcodeMask = 8'h0F;
  localparam logic [7:0] MaskFlag   = 8'h80;
  localparam logic [7:0] Len7Mask   = 8'h7F;
  localparam logic [6:0] LenExt16   = 7'd126;
  localparam logic [6:0] LenExt64   = 7'd127;

  localparam logic [2:0] Ext16LastIdx = 3'd1;
  localparam logic [2:0] Ext64LastIdx = 3'd7;
  localparam logic [2:0] KeyLastIdx   = 3'd3;

  localparam int unsigned OutTdataW = 80;

  // Result kinds carried on tuser
  localparam logic KindHeader  = 1'b0;
  localparam logic KindPayload = 1'b1;

endpackage

// ----- design/websocket_frame_deframer.sv -----
// WebSocket frame deframer: parses received frame bytes, emits headers and unmasked payload.
//
// Slave stream (s_axis_*): one received byte per beat in tdata[7:0].
// Master stream (m_axis_*): one result per beat.
//   tuser  : kind, 0 = header complete, 1 = unmasked payload byte.
//   tdata  : opcode [3:0], payload length [67:4], data byte [75:68], zeros [79:76].
//   tlast  : final result of a frame (header of a zero-length frame, or last
//            payload byte).
// Header bytes (first and second byte, extended length, mask key) produce no beat; the
// header beat appears with the byte that completes the header.
// A taken byte is parsed from the input register and its result is loaded
// into the output register when the parse stage can move. Throughput is one
// byte per cycle while results are taken, set by the combinational parse
// stage between the input and output registers. The input register keeps
// taking bytes while an unconsumed result waits, as long as the parse stage
// can move; when the receiver holds tready low with a result pending, the
// parse stage stops and s_axis_tready_o drops once the input register is full.
// Reset clears the parser to "expect first header byte" and empties both
// registers.
module websocket_frame_deframer
  import wsdf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [7:0]           s_axis_tdata_i,   // [7:0] rx_byte
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [OutTdataW-1:0] m_axis_tdata_o,   // [3:0] frame_opcode, [67:4] frame_length,
                                                 // [75:68] data_byte, [79:76] zero
  output logic                 m_axis_tuser_o,   // [0] kind
  output logic                 m_axis_tlast_o
);

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;

  // parser state
  phase_e      phase_q, phase_d;
  logic [3:0]  opcode_q, opcode_d;
  logic        mask_on_q, mask_on_d;
  logic [63:0] length_q, length_d;
  logic [2:0]  hdr_cnt_q, hdr_cnt_d;
  logic [31:0] mask_key_q, mask_key_d;
  logic [63:0] remain_q, remain_d;
  logic [1:0]  mask_idx_q, mask_idx_d;

  // result register
  logic        out_valid_q;
  logic        out_kind_q;
  logic [3:0]  out_opcode_q;
  logic [63:0] out_length_q;
  logic [7:0]  out_data_q;
  logic        out_last_q;

  logic        res_valid;
  logic        res_kind;
  logic [7:0]  res_data;
  logic        res_last;
  logic        advance;
  logic [7:0]  key_byte;
  logic [6:0]  len7;
  logic [2:0]  final_idx;
  logic        len_done;
  logic        hdr_done;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign len7            = 7'(in_byte_q & Len7Mask);

  always_comb begin
    unique case (mask_idx_q)
      2'd0:    key_byte = mask_key_q[31:24];
      2'd1:    key_byte = mask_key_q[23:16];
      2'd2:    key_byte = mask_key_q[15:8];
      default: key_byte = mask_key_q[7:0];
    endcase
  end

  always_comb begin
    phase_d    = phase_q;
    opcode_d   = opcode_q;
    mask_on_d  = mask_on_q;
    length_d   = length_q;
    hdr_cnt_d  = hdr_cnt_q;
    mask_key_d = mask_key_q;
    remain_d   = remain_q;
    mask_idx_d = mask_idx_q;
    res_valid  = 1'b0;
    res_kind   = KindHeader;
    res_data   = 8'd0;
    res_last   = 1'b0;
    len_done   = 1'b0;
    hdr_done   = 1'b0;
    final_idx  = (phase_q == PH_EXT16) ? Ext16LastIdx : Ext64LastIdx;

    unique case (phase_q)
      PH_HDR1: begin
        mask_on_d  = (in_byte_q & MaskFlag) != 8'd0;
        mask_key_d = '0;
        hdr_cnt_d  = '0;
        length_d   = '0;
        if (len7 == LenExt16) begin
          phase_d = PH_EXT16;
        end else if (len7 == LenExt64) begin
          phase_d = PH_EXT64;
        end else begin
          length_d = {57'd0, len7};
          len_done = 1'b1;
        end
      end
      PH_EXT16, PH_EXT64: begin
        length_d = {length_q[55:0], in_byte_q};
        if (hdr_cnt_q >= final_idx) begin
          len_done = 1'b1;
        end else begin
          hdr_cnt_d = hdr_cnt_q + 3'd1;
        end
      end
      PH_KEY: begin
        mask_key_d = {mask_key_q[23:0], in_byte_q};
        if (hdr_cnt_q >= KeyLastIdx) begin
          hdr_done = 1'b1;
        end else begin
          hdr_cnt_d = hdr_cnt_q + 3'd1;
        end
      end
      PH_DATA: begin
        mask_idx_d = mask_idx_q + 2'd1;
        if (remain_q != 64'd0) remain_d = remain_q - 64'd1;
        res_valid = 1'b1;
        res_kind  = KindPayload;
        res_data  = in_byte_q ^ key_byte;
        res_last  = (remain_q <= 64'd1);
        if (res_last) phase_d = PH_HDR0;
      end
      default: begin
        opcode_d = 4'(in_byte_q & OpcodeMask);
        phase_d  = PH_HDR1;
      end
    endcase

    if (len_done) begin
      hdr_cnt_d = '0;
      if (mask_on_d) begin
        phase_d = PH_KEY;
      end else begin
        hdr_done = 1'b1;
      end
    end

    // header complete: header beat, then payload or next frame
    if (hdr_done) begin
      hdr_cnt_d  = '0;
      mask_idx_d = '0;
      remain_d   = length_d;
      res_valid  = 1'b1;
      res_kind   = KindHeader;
      res_data   = 8'd0;
      res_last   = (length_d == 64'd0);
      phase_d    = res_last ? PH_HDR0 : PH_DATA;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) in_byte_q <= s_axis_tdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HDR0;
      opcode_q   <= '0;
      mask_on_q  <= 1'b0;
      length_q   <= '0;
      hdr_cnt_q  <= '0;
      mask_key_q <= '0;
      remain_q   <= '0;
      mask_idx_q <= '0;
    end else if (advance) begin
      phase_q    <= phase_d;
      opcode_q   <= opcode_d;
      mask_on_q  <= mask_on_d;
      length_q   <= length_d;
      hdr_cnt_q  <= hdr_cnt_d;
      mask_key_q <= mask_key_d;
      remain_q   <= remain_d;
      mask_idx_q <= mask_idx_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // opcode and length as they stand after this byte
  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_kind_q   <= res_kind;
      out_opcode_q <= opcode_d;
      out_length_q <= length_d;
      out_data_q   <= res_data;
      out_last_q   <= res_last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {4'd0, out_data_q, out_length_q, out_opcode_q};

endmodule
